FILE: hdl/slcd_pkg.sv
package slcd_pkg;

	// Result kinds on the display write channel
	localparam logic [1:0] KIND_CMD   = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_LIGHT = 2'd2;

	// Byte that opens an escape sequence
	localparam logic [7:0] ESC_BYTE = 8'd254;

	// Escape command bytes
	localparam logic [7:0] ESC_HOME         = 8'd72;
	localparam logic [7:0] ESC_UNDERLINE_ON = 8'd74;
	localparam logic [7:0] ESC_UNDERLINE_OFF = 8'd75;
	localparam logic [7:0] ESC_BLINK_OFF    = 8'd84;
	localparam logic [7:0] ESC_LEFT         = 8'd76;
	localparam logic [7:0] ESC_RIGHT        = 8'd77;
	localparam logic [7:0] ESC_BLINK_ON     = 8'd83;
	localparam logic [7:0] ESC_CLEAR        = 8'd88;
	localparam logic [7:0] ESC_POSITION     = 8'd71;
	localparam logic [7:0] ESC_GLYPH        = 8'd78;
	localparam logic [7:0] ESC_LIGHT_A      = 8'd152;
	localparam logic [7:0] ESC_LIGHT_B      = 8'd153;

	// Display controller instruction bytes
	localparam logic [7:0] LCD_CLEAR       = 8'h01;
	localparam logic [7:0] LCD_HOME        = 8'h02;
	localparam logic [7:0] LCD_CURSOR_LINE = 8'h0E;
	localparam logic [7:0] LCD_CURSOR_OFF  = 8'h0C;
	localparam logic [7:0] LCD_CURSOR_BLK  = 8'h0F;
	localparam logic [7:0] LCD_SHIFT_LEFT  = 8'h10;
	localparam logic [7:0] LCD_SHIFT_RIGHT = 8'h14;
	localparam logic [7:0] LCD_SET_DDRAM   = 8'h80;
	localparam logic [7:0] LCD_SET_CGRAM   = 8'h40;

	// Row offsets in display memory
	localparam logic [7:0] ROW2_NUM = 8'd2;
	localparam logic [7:0] ROW3_NUM = 8'd3;
	localparam logic [7:0] ROW4_NUM = 8'd4;
	localparam logic [7:0] ROW2_OFS = 8'h40;
	localparam logic [7:0] ROW3_OFS = 8'h14;
	localparam logic [7:0] ROW4_OFS = 8'h54;

	// Backlight threshold
	localparam logic [7:0] LIGHT_LIMIT = 8'd128;

	// Escape commands that are accepted and ignored, with no parameter byte
	localparam int NUM_NOP = 18;
	localparam logic [7:0] NOP_CODES [NUM_NOP] = '{
		8'd66, 8'd70, 8'd86, 8'd87, 8'd35, 8'd36, 8'd55, 8'd59, 8'd65,
		8'd96, 8'd67, 8'd68, 8'd81, 8'd82, 8'd104, 8'd109, 8'd115, 8'd118
	};

	typedef struct packed {
		logic       emit;
		logic [1:0] kind;
		logic [7:0] value;
	} slcd_result_t;

endpackage

FILE: hdl/slcd_rx_if.sv
interface slcd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/slcd_wr_if.sv
interface slcd_wr_if;
	logic       valid;
	logic       ready;
	logic [1:0] write_kind;
	logic [7:0] write_value;

	modport source (output valid, output write_kind, output write_value, input ready);
	modport sink (input valid, input write_kind, input write_value, output ready);
endinterface

FILE: hdl/serial_lcd_command_parser.sv
// Serial character-display command parser.
// rx (sink): one received serial byte per transfer, valid/ready handshake.
// wr (source): display bus writes; write_kind 0 is an instruction, 1 is
//   display data, 2 sets the backlight pin to write_value (0 or 1).
// A plain byte gives one data write. Byte 254 opens an escape whose next
// byte picks a command; parameter bytes (cursor column and row, glyph address
// and GLYPH_ROWS pattern bytes, backlight level) give at most one write each.
// Many bytes, such as the escape byte itself, give no write at all.
// A write appears on wr in the cycle after the byte's transfer on rx.
// Throughput: one byte per cycle unless a write waits on a stalled receiver;
// the parser's mode, column and glyph-count registers are its only loops.
// The result sits in an output register; rx stays ready while that register
// is empty or is being drained in the same cycle, so a stalled receiver
// holds wr steady and stops rx only while a write is waiting.
// Reset returns the parser to plain-byte mode, clears the saved column and
// glyph count, and empties the output register.
module serial_lcd_command_parser #(
	parameter int GLYPH_ROWS = 8
) (
	input logic      clk,
	input logic      arst_n,
	slcd_rx_if.sink  rx,
	slcd_wr_if.source wr
);

	slcd_pkg::slcd_result_t result;
	logic                   take;
	logic                   valid_q;
	logic [1:0]             kind_q;
	logic [7:0]             value_q;

	// accept a new byte whenever the output register is free or draining
	assign rx.ready = !valid_q || wr.ready;
	assign take     = rx.valid && rx.ready;

	slcd_parser #(
		.GLYPH_ROWS(GLYPH_ROWS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.rx_byte(rx.rx_byte),
		.result (result)
	);

	// output register: load on a write, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take && result.emit) begin
			valid_q <= 1'b1;
		end else if (wr.ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload holds while the receiver stalls
	always_ff @(posedge clk) begin
		if (take && result.emit) begin
			kind_q  <= result.kind;
			value_q <= result.value;
		end
	end

	assign wr.valid       = valid_q;
	assign wr.write_kind  = kind_q;
	assign wr.write_value = value_q;

endmodule

FILE: hdl/slcd_parser.sv
module slcd_parser #(
	parameter int GLYPH_ROWS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            rx_byte,
	output slcd_pkg::slcd_result_t result
);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_ESCAPE,
		MODE_COLUMN,
		MODE_ROW,
		MODE_GADDR,
		MODE_GDATA,
		MODE_LIGHT,
		MODE_SKIP
	} mode_t;

	localparam logic [3:0] GLYPH_LOAD = 4'(GLYPH_ROWS);

	mode_t      mode_q, mode_d;
	logic [7:0] column_q, column_d;
	logic [3:0] glyph_left_q, glyph_left_d;
	logic       is_nop;
	logic [7:0] row_ofs;
	logic [3:0] glyph_dec;

	always_comb begin
		is_nop = 1'b0;
		for (int i = 0; i < slcd_pkg::NUM_NOP; i++) begin
			if (rx_byte == slcd_pkg::NOP_CODES[i]) begin
				is_nop = 1'b1;
			end
		end
	end

	always_comb begin
		case (rx_byte)
			slcd_pkg::ROW2_NUM: row_ofs = slcd_pkg::ROW2_OFS;
			slcd_pkg::ROW3_NUM: row_ofs = slcd_pkg::ROW3_OFS;
			slcd_pkg::ROW4_NUM: row_ofs = slcd_pkg::ROW4_OFS;
			default:            row_ofs = 8'd0;
		endcase
	end

	assign glyph_dec = glyph_left_q - 4'd1;

	always_comb begin
		mode_d       = mode_q;
		column_d     = column_q;
		glyph_left_d = glyph_left_q;
		result       = '0;
		case (mode_q)
			MODE_IDLE: begin
				if (rx_byte == slcd_pkg::ESC_BYTE) begin
					mode_d = MODE_ESCAPE;
				end else begin
					result = '{1'b1, slcd_pkg::KIND_DATA, rx_byte};
				end
			end
			MODE_ESCAPE: begin
				mode_d = MODE_IDLE;
				case (rx_byte)
					slcd_pkg::ESC_HOME:
						result = '{1'b1, slcd_pkg::KIND_CMD, slcd_pkg::LCD_HOME};
					slcd_pkg::ESC_UNDERLINE_ON:
						result = '{1'b1, slcd_pkg::KIND_CMD, slcd_pkg::LCD_CURSOR_LINE};
					slcd_pkg::ESC_UNDERLINE_OFF, slcd_pkg::ESC_BLINK_OFF:
						result = '{1'b1, slcd_pkg::KIND_CMD, slcd_pkg::LCD_CURSOR_OFF};
					slcd_pkg::ESC_LEFT:
						result = '{1'b1, slcd_pkg::KIND_CMD, slcd_pkg::LCD_SHIFT_LEFT};
					slcd_pkg::ESC_RIGHT:
						result = '{1'b1, slcd_pkg::KIND_CMD, slcd_pkg::LCD_SHIFT_RIGHT};
					slcd_pkg::ESC_BLINK_ON:
						result = '{1'b1, slcd_pkg::KIND_CMD, slcd_pkg::LCD_CURSOR_BLK};
					slcd_pkg::ESC_CLEAR:
						result = '{1'b1, slcd_pkg::KIND_CMD, slcd_pkg::LCD_CLEAR};
					slcd_pkg::ESC_POSITION: mode_d = MODE_COLUMN;
					slcd_pkg::ESC_GLYPH:    mode_d = MODE_GADDR;
					slcd_pkg::ESC_LIGHT_A, slcd_pkg::ESC_LIGHT_B: mode_d = MODE_LIGHT;
					default: begin
						// unknown commands not in the NOP list swallow one parameter byte
						if (!is_nop) begin
							mode_d = MODE_SKIP;
						end
					end
				endcase
			end
			MODE_COLUMN: begin
				column_d = rx_byte - 8'd1;
				mode_d   = MODE_ROW;
			end
			MODE_ROW: begin
				mode_d = MODE_IDLE;
				result = '{1'b1, slcd_pkg::KIND_CMD,
					slcd_pkg::LCD_SET_DDRAM + column_q + row_ofs};
			end
			MODE_GADDR: begin
				glyph_left_d = GLYPH_LOAD;
				mode_d       = (GLYPH_LOAD != 4'd0) ? MODE_GDATA : MODE_IDLE;
				result = '{1'b1, slcd_pkg::KIND_CMD,
					slcd_pkg::LCD_SET_CGRAM + {rx_byte[4:0], 3'b000}};
			end
			MODE_GDATA: begin
				glyph_left_d = glyph_dec;
				if (glyph_dec == 4'd0) begin
					mode_d = MODE_IDLE;
				end
				result = '{1'b1, slcd_pkg::KIND_DATA, rx_byte};
			end
			MODE_LIGHT: begin
				mode_d = MODE_IDLE;
				result = '{1'b1, slcd_pkg::KIND_LIGHT,
					(rx_byte > slcd_pkg::LIGHT_LIMIT) ? 8'd0 : 8'd1};
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			column_q     <= 8'd0;
			glyph_left_q <= 4'd0;
		end else if (take) begin
			mode_q       <= mode_d;
			column_q     <= column_d;
			glyph_left_q <= glyph_left_d;
		end
	end

endmodule
